@@ rtl/tlpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types, codes and constants of the two-level page table unit.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int VA_W       = 32;
    localparam int FRAME_W    = 20;
    localparam int FLAG_W     = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = 10;
    localparam int DIR_LSB    = 22;
    localparam int STATUS_W   = 3;

    localparam logic [FLAG_W-1:0] CFG_FLAGS_RESET = 12'h003;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_UNMAP     = 2'd2,
        OP_ALLOC     = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_NOT_MAPPED     = 3'd1,
        ST_ALREADY_MAPPED = 3'd2,
        ST_NO_SLOT        = 3'd3,
        ST_ZERO_ADDR      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_PTE
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic pte_read;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

endpackage

@@ rtl/tlpt_if.sv @@
// ----------------------------------------------------------------------------
// tlpt_if
// Request and response channels of the page table unit.
// ----------------------------------------------------------------------------
interface tlpt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] virt_addr;
    logic [19:0] frame_in;
    logic [11:0] entry_flags;

    modport source (output valid, output opcode, output virt_addr, output frame_in,
                    output entry_flags, input ready);
    modport sink   (input valid, input opcode, input virt_addr, input frame_in,
                    input entry_flags, output ready);
endinterface

interface tlpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [19:0] frame_out;
    logic [11:0] flags_out;
    logic        table_freed;

    modport source (output valid, output status, output frame_out, output flags_out,
                    output table_freed, input ready);
    modport sink   (input valid, input status, input frame_out, input flags_out,
                    input table_freed, output ready);
endinterface

@@ rtl/tlpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer: clearing pass, then directory read, table read, write-back.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  tlpt_pkg::t_dp_status i_status,
    output tlpt_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_ready,
    output logic                 o_out_valid
);

    tlpt_pkg::t_state r_state;
    tlpt_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_can_commit;

    // write-back needs a free output register
    assign w_can_commit = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlpt_pkg::S_CLEAR: begin
                if (i_status.clear_last) n_state = tlpt_pkg::S_IDLE;
            end
            tlpt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tlpt_pkg::S_DIR;
            end
            tlpt_pkg::S_DIR: begin
                n_state = tlpt_pkg::S_PTE;
            end
            tlpt_pkg::S_PTE: begin
                if (w_can_commit) n_state = tlpt_pkg::S_IDLE;
            end
            default: begin
                n_state = tlpt_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        o_cmd.clear_step = (r_state == tlpt_pkg::S_CLEAR);
        o_in_ready       = (r_state == tlpt_pkg::S_IDLE);
        o_cmd.accept     = (r_state == tlpt_pkg::S_IDLE) && i_in_valid;
        o_cmd.pte_read   = (r_state == tlpt_pkg::S_DIR);
        o_cmd.commit     = (r_state == tlpt_pkg::S_PTE) && w_can_commit;
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlpt_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("result word not presented after write-back");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlpt_pkg::S_PTE && r_out_valid && !i_out_ready)
            |=> r_state == tlpt_pkg::S_PTE)
        else $error("write-back left while output register full");

    a_accept_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == tlpt_pkg::S_DIR) ##1 (r_state == tlpt_pkg::S_PTE))
        else $error("accepted word did not reach table read");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlpt_pkg::S_CLEAR) |-> !o_cmd.accept && !o_cmd.commit)
        else $error("activity during clearing pass");

endmodule

@@ rtl/tlpt_datapath.sv @@
// ----------------------------------------------------------------------------
// tlpt_datapath
// Directory, page table pool, present counts, free slot stack and result regs.
// ----------------------------------------------------------------------------
module tlpt_datapath #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int TABLE_SLOTS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlpt_pkg::t_dp_cmd    i_cmd,
    output tlpt_pkg::t_dp_status o_status,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_data,
    input  logic [1:0]           i_opcode,
    input  logic [31:0]          i_virt_addr,
    input  logic [19:0]          i_frame_in,
    input  logic [11:0]          i_entry_flags,
    output tlpt_pkg::t_status    o_status_code,
    output logic [19:0]          o_frame_out,
    output logic [11:0]          o_flags_out,
    output logic                 o_table_freed
);

    localparam int DIR_AW    = $clog2(DIR_ENTRIES);
    localparam int TBL_AW    = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int FREE_W    = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int PAGES     = TABLE_SLOTS * TABLE_ENTRIES;
    localparam int PAGE_AW   = $clog2(PAGES);
    localparam int CLR_A     = (PAGES > DIR_ENTRIES) ? PAGES : DIR_ENTRIES;
    localparam int CLR_DEPTH = (CLR_A > TABLE_SLOTS) ? CLR_A : TABLE_SLOTS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int IDX_W     = tlpt_pkg::IDX_W;

    // reciprocal constants for reducing a 10-bit index modulo the table sizes
    localparam int DIR_SH  = IDX_W + $clog2(DIR_ENTRIES);
    localparam int TBL_SH  = IDX_W + $clog2(TABLE_ENTRIES);
    localparam int DIR_RCP = ((1 << DIR_SH) + DIR_ENTRIES - 1) / DIR_ENTRIES;
    localparam int TBL_RCP = ((1 << TBL_SH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [11:0]       flags;
    } t_dir_entry;

    // memories
    t_dir_entry        r_dir_mem [DIR_ENTRIES];
    logic [31:0]       r_pg_mem  [PAGES];
    logic [CNT_W-1:0]  r_cnt_mem [TABLE_SLOTS];
    logic [SLOT_W-1:0] r_stack   [TABLE_SLOTS];

    t_dir_entry        r_dir_rd;
    logic [31:0]       r_pg_rd;
    logic [CNT_W-1:0]  r_cnt_rd;
    logic [SLOT_W-1:0] r_free_top;

    // request word
    tlpt_pkg::t_opcode r_op;
    logic [31:0]       r_va;
    logic [19:0]       r_frame;
    logic [11:0]       r_eflags;
    logic [DIR_AW-1:0] r_di;
    logic [TBL_AW-1:0] r_ti;
    logic [SLOT_W-1:0] r_slot;
    logic [PAGE_AW-1:0] r_pg_addr;

    logic [11:0]       r_tef;
    logic [FREE_W-1:0] r_free_cnt;
    logic [FREE_W-1:0] n_free_cnt;
    logic [CLR_W-1:0]  r_clr_addr;

    tlpt_pkg::t_status r_status_code;
    logic [19:0]       r_frame_out;
    logic [11:0]       r_flags_out;
    logic              r_table_freed;

    logic [IDX_W-1:0]   w_di_raw;
    logic [31:0]        w_di_prod;
    logic [IDX_W-1:0]   w_di_quo;
    logic [IDX_W-1:0]   w_di_rem;
    logic [IDX_W-1:0]   w_ti_raw;
    logic [31:0]        w_ti_prod;
    logic [IDX_W-1:0]   w_ti_quo;
    logic [IDX_W-1:0]   w_ti_rem;
    logic [DIR_AW-1:0]  w_di_in;
    logic [TBL_AW-1:0]  w_ti_in;
    logic [SLOT_W-1:0]  n_slot;
    logic [PAGE_AW:0]   w_pg_addr_full;
    logic [FREE_W-1:0]  w_free_dec;
    logic               w_clr_dir;
    logic               w_clr_pg;
    logic               w_clr_slot;

    // write-back decisions
    tlpt_pkg::t_status w_status;
    logic [19:0]       w_fout;
    logic [11:0]       w_flout;
    logic              w_freed;
    logic              w_pg_we;
    logic [31:0]       w_pg_wdata;
    logic              w_cnt_we;
    logic [CNT_W-1:0]  w_cnt_wdata;
    logic              w_dir_we;
    t_dir_entry        w_dir_wdata;
    logic              w_pop;
    logic              w_push;
    logic              w_new_tbl;
    logic              w_present;
    logic [CNT_W-1:0]  w_base_cnt;
    logic [CNT_W-1:0]  w_unmap_cnt;

    // remainder = x - floor(x * rcp / 2^sh) * n, exact for every 10-bit x
    assign w_di_raw  = i_virt_addr[tlpt_pkg::DIR_LSB +: IDX_W];
    assign w_di_prod = 32'(w_di_raw) * 32'(DIR_RCP);
    assign w_di_quo  = w_di_prod[DIR_SH +: IDX_W];
    assign w_di_rem  = w_di_raw - IDX_W'(20'(w_di_quo) * 20'(DIR_ENTRIES));
    assign w_di_in   = DIR_AW'(w_di_rem);

    assign w_ti_raw  = i_virt_addr[tlpt_pkg::PAGE_SHIFT +: IDX_W];
    assign w_ti_prod = 32'(w_ti_raw) * 32'(TBL_RCP);
    assign w_ti_quo  = w_ti_prod[TBL_SH +: IDX_W];
    assign w_ti_rem  = w_ti_raw - IDX_W'(20'(w_ti_quo) * 20'(TABLE_ENTRIES));
    assign w_ti_in   = TBL_AW'(w_ti_rem);

    // existing table, or the slot on top of the free stack
    assign n_slot = r_dir_rd.valid ? r_dir_rd.slot : r_free_top;
    assign w_pg_addr_full = (PAGE_AW + 1)'(n_slot) * (PAGE_AW + 1)'(TABLE_ENTRIES)
                          + (PAGE_AW + 1)'(r_ti);
    assign w_free_dec = r_free_cnt - 1'b1;

    assign w_clr_dir  = {1'b0, r_clr_addr} < (CLR_W + 1)'(DIR_ENTRIES);
    assign w_clr_pg   = {1'b0, r_clr_addr} < (CLR_W + 1)'(PAGES);
    assign w_clr_slot = {1'b0, r_clr_addr} < (CLR_W + 1)'(TABLE_SLOTS);

    assign o_status.clear_last = (r_clr_addr == CLR_W'(CLR_DEPTH - 1));

    always_comb begin
        w_status    = tlpt_pkg::ST_OK;
        w_fout      = '0;
        w_flout     = '0;
        w_freed     = 1'b0;
        w_pg_we     = 1'b0;
        w_pg_wdata  = '0;
        w_cnt_we    = 1'b0;
        w_cnt_wdata = '0;
        w_dir_we    = 1'b0;
        w_dir_wdata = '0;
        w_pop       = 1'b0;
        w_push      = 1'b0;
        w_new_tbl   = !r_dir_rd.valid;
        // a free table never holds a present entry
        w_present   = r_pg_rd[0] && r_dir_rd.valid;
        w_base_cnt  = r_dir_rd.valid ? r_cnt_rd : '0;
        w_unmap_cnt = (w_present && w_base_cnt != '0) ? w_base_cnt - 1'b1 : w_base_cnt;
        if (r_op != tlpt_pkg::OP_MAP && r_va == '0) begin
            w_status = tlpt_pkg::ST_ZERO_ADDR;
        end else begin
            case (r_op)
                tlpt_pkg::OP_MAP, tlpt_pkg::OP_ALLOC: begin
                    if (w_new_tbl && r_free_cnt == '0) begin
                        w_status = tlpt_pkg::ST_NO_SLOT;
                    end else if (r_op == tlpt_pkg::OP_ALLOC && w_present) begin
                        w_status = tlpt_pkg::ST_ALREADY_MAPPED;
                    end else begin
                        w_pg_we    = 1'b1;
                        w_pg_wdata = {r_frame, r_eflags};
                        w_cnt_we   = 1'b1;
                        if (!w_present && r_eflags[0]) begin
                            w_cnt_wdata = w_base_cnt + 1'b1;
                        end else if (w_present && !r_eflags[0] && w_base_cnt != '0) begin
                            w_cnt_wdata = w_base_cnt - 1'b1;
                        end else begin
                            w_cnt_wdata = w_base_cnt;
                        end
                        if (w_new_tbl) begin
                            w_dir_we    = 1'b1;
                            w_dir_wdata = '{valid: 1'b1, slot: r_slot, flags: r_tef};
                            w_pop       = 1'b1;
                        end
                    end
                end
                tlpt_pkg::OP_TRANSLATE: begin
                    if (!w_present) begin
                        w_status = tlpt_pkg::ST_NOT_MAPPED;
                    end else begin
                        w_fout  = r_pg_rd[31:tlpt_pkg::PAGE_SHIFT];
                        w_flout = r_pg_rd[tlpt_pkg::FLAG_W-1:0];
                    end
                end
                tlpt_pkg::OP_UNMAP: begin
                    if (w_new_tbl) begin
                        w_status = tlpt_pkg::ST_NOT_MAPPED;
                    end else begin
                        if (w_present) begin
                            w_fout  = r_pg_rd[31:tlpt_pkg::PAGE_SHIFT];
                            w_pg_we = 1'b1;
                        end else begin
                            w_status = tlpt_pkg::ST_NOT_MAPPED;
                        end
                        w_cnt_we    = 1'b1;
                        w_cnt_wdata = w_unmap_cnt;
                        // empty table goes back to the pool
                        if (w_unmap_cnt == '0) begin
                            w_dir_we = 1'b1;
                            w_push   = 1'b1;
                            w_freed  = 1'b1;
                        end
                    end
                end
                default: begin
                    w_status = tlpt_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        n_free_cnt = r_free_cnt;
        if (i_cmd.commit && w_pop) begin
            n_free_cnt = r_free_cnt - 1'b1;
        end else if (i_cmd.commit && w_push) begin
            n_free_cnt = r_free_cnt + 1'b1;
        end
    end

    // directory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && w_clr_dir) begin
            r_dir_mem[r_clr_addr[DIR_AW-1:0]] <= '0;
        end else if (i_cmd.commit && w_dir_we) begin
            r_dir_mem[r_di] <= w_dir_wdata;
        end
        if (i_cmd.accept) begin
            r_dir_rd <= r_dir_mem[w_di_in];
        end
    end

    // page table pool
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && w_clr_pg) begin
            r_pg_mem[r_clr_addr[PAGE_AW-1:0]] <= '0;
        end else if (i_cmd.commit && w_pg_we) begin
            r_pg_mem[r_pg_addr] <= w_pg_wdata;
        end
        if (i_cmd.pte_read) begin
            r_pg_rd <= r_pg_mem[w_pg_addr_full[PAGE_AW-1:0]];
        end
    end

    // present counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && w_clr_slot) begin
            r_cnt_mem[r_clr_addr[SLOT_W-1:0]] <= '0;
        end else if (i_cmd.commit && w_cnt_we) begin
            r_cnt_mem[r_slot] <= w_cnt_wdata;
        end
        if (i_cmd.pte_read) begin
            r_cnt_rd <= r_cnt_mem[n_slot];
        end
    end

    // free slot stack, filled with every slot number during the clearing pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && w_clr_slot) begin
            r_stack[r_clr_addr[SLOT_W-1:0]] <= r_clr_addr[SLOT_W-1:0];
        end else if (i_cmd.commit && w_push) begin
            r_stack[r_free_cnt[SLOT_W-1:0]] <= r_slot;
        end
        if (i_cmd.accept) begin
            r_free_top <= r_stack[w_free_dec[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= tlpt_pkg::t_opcode'(i_opcode);
            r_va     <= i_virt_addr;
            r_frame  <= i_frame_in;
            r_eflags <= i_entry_flags;
            r_di     <= w_di_in;
            r_ti     <= w_ti_in;
        end
        if (i_cmd.pte_read) begin
            r_slot    <= n_slot;
            r_pg_addr <= w_pg_addr_full[PAGE_AW-1:0];
        end
        if (i_cmd.commit) begin
            r_status_code <= w_status;
            r_frame_out   <= w_fout;
            r_flags_out   <= w_flout;
            r_table_freed <= w_freed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tef      <= tlpt_pkg::CFG_FLAGS_RESET;
            r_free_cnt <= FREE_W'(TABLE_SLOTS);
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) r_tef <= i_cfg_data;
            r_free_cnt <= n_free_cnt;
            if (i_cmd.clear_step && !o_status.clear_last) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_status_code = r_status_code;
    assign o_frame_out   = r_frame_out;
    assign o_flags_out   = r_flags_out;
    assign o_table_freed = r_table_freed;

    a_free_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= FREE_W'(TABLE_SLOTS))
        else $error("free slot count beyond pool size");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_push) |-> r_free_cnt < FREE_W'(TABLE_SLOTS))
        else $error("table freed while pool already full");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_pop) |-> (r_free_cnt != '0) && !w_push)
        else $error("table taken from an empty pool");

endmodule

@@ rtl/two_level_page_table_unit.sv @@
// ----------------------------------------------------------------------------
// two_level_page_table_unit
// Page directory plus a pool of page tables: map, translate, unmap and
// alloc-if-absent, one page per request word.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  i_req     in    valid/ready          opcode, virt_addr, frame_in, entry_flags
//  o_rsp     out   valid/ready          status, frame_out, flags_out, table_freed
//  i_cfg     in    i_cfg_we, no wait    i_cfg_data (table_entry_flags)
//
//  each word passes directory read, page table read and write-back in turn,
//  the order set by the chained synchronous reads of the directory and table memories
//  after reset a clearing pass over every directory entry, page table entry,
//  present count and stack slot keeps i_req.ready low; config writes still land
//  a result word waits in the output register while the next request is taken;
//  write-back holds until that register is free
// ----------------------------------------------------------------------------
module two_level_page_table_unit #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int TABLE_SLOTS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlpt_req_if.sink    i_req,
    tlpt_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data
);

    tlpt_pkg::t_dp_cmd    w_cmd;
    tlpt_pkg::t_dp_status w_dp_status;
    tlpt_pkg::t_status    w_status_code;
    logic                 w_in_ready;
    logic                 w_out_valid;

    tlpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_dp_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid)
    );

    tlpt_datapath #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TABLE_SLOTS   (TABLE_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_dp_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_req.opcode),
        .i_virt_addr   (i_req.virt_addr),
        .i_frame_in    (i_req.frame_in),
        .i_entry_flags (i_req.entry_flags),
        .o_status_code (w_status_code),
        .o_frame_out   (o_rsp.frame_out),
        .o_flags_out   (o_rsp.flags_out),
        .o_table_freed (o_rsp.table_freed)
    );

    assign i_req.ready  = w_in_ready;
    assign o_rsp.valid  = w_out_valid;
    assign o_rsp.status = w_status_code;

endmodule
